// ----- rtl/rtac_pkg.sv -----
package rtac_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam logic [15:0] WRITE_RIGHT_MASK = 16'd2;

    localparam int DATA_W   = 64;
    localparam int PERM_W   = 16;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] HINT_NONE  = CNT_W'(TABLE_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_INVALID   = 3'd1,
        STS_FULL      = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_DENIED    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_HINT_EV,
        S_SCAN,
        S_MOVE_WR
    } state_t;

    // A classified command as it leaves the front end.
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] address;
        logic [DATA_W-1:0] end_addr;
        logic [PERM_W-1:0] rights;
        logic              zero_len;
        logic              wrap;
        logic              use_write;
    } cmd_t;

    // Regions are stored with their end address instead of their length.
    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] end_addr;
        logic [PERM_W-1:0] rights;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/rtac_req_if.sv -----
interface rtac_req_if;

    logic                          valid;
    logic                          ready;
    logic [rtac_pkg::OP_W-1:0]     operation;
    logic [rtac_pkg::DATA_W-1:0]   address;
    logic [rtac_pkg::DATA_W-1:0]   length;
    logic [rtac_pkg::PERM_W-1:0]   permissions;

    modport source (
        output valid, operation, address, length, permissions,
        input  ready
    );

    modport sink (
        input  valid, operation, address, length, permissions,
        output ready
    );

endinterface

// ----- rtl/rtac_rsp_if.sv -----
interface rtac_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [rtac_pkg::STATUS_W-1:0] status;
    logic [rtac_pkg::COUNT_W-1:0]  region_count;

    modport source (
        output valid, status, region_count,
        input  ready
    );

    modport sink (
        input  valid, status, region_count,
        output ready
    );

endinterface

// ----- rtl/rtac_ram.sv -----
module rtac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/rtac_front.sv -----
module rtac_front (
    rtac_req_if.sink        req,
    input  logic            push_ready,
    output logic            push_valid,
    output rtac_pkg::cmd_t  push_cmd
);

    logic [rtac_pkg::DATA_W:0] sum;

    // The span end is formed once here; the back end only compares.
    assign sum = {1'b0, req.address} + {1'b0, req.length};

    always_comb
    begin
        push_cmd.op        = rtac_pkg::op_t'(req.operation);
        push_cmd.address   = req.address;
        push_cmd.end_addr  = sum[rtac_pkg::DATA_W-1:0];
        push_cmd.rights    = req.permissions;
        push_cmd.zero_len  = (req.length == '0);
        push_cmd.wrap      = sum[rtac_pkg::DATA_W];
        push_cmd.use_write = |(req.permissions & rtac_pkg::WRITE_RIGHT_MASK);
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

endmodule

// ----- rtl/rtac_queue.sv -----
module rtac_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  rtac_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output rtac_pkg::cmd_t  pop_cmd
);

    rtac_pkg::cmd_t               slot_reg [rtac_pkg::QUEUE_DEPTH];
    logic [rtac_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rtac_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rtac_pkg::QCNT_W-1:0]  fill_reg, fill_next;
    logic                         push;
    logic                         pop;

    assign push_ready = (fill_reg != rtac_pkg::QCNT_W'(rtac_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == rtac_pkg::QPTR_W'(rtac_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + rtac_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rtac_pkg::QPTR_W'(rtac_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + rtac_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + rtac_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - rtac_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/rtac_back.sv -----
module rtac_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  rtac_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    rtac_rsp_if.source      rsp
);

    rtac_pkg::state_t             state_reg, state_next;
    rtac_pkg::cmd_t               cmd_reg, cmd_next;
    logic [rtac_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [rtac_pkg::CNT_W-1:0]   read_hint_reg, read_hint_next;
    logic [rtac_pkg::CNT_W-1:0]   write_hint_reg, write_hint_next;
    logic [rtac_pkg::CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                         eval_valid_reg, eval_valid_next;
    logic [rtac_pkg::ADDR_W-1:0]  eval_idx_reg, eval_idx_next;
    logic                         out_valid_reg, out_valid_next;
    rtac_pkg::status_t            out_status_reg, out_status_next;
    logic [rtac_pkg::CNT_W-1:0]   out_count_reg, out_count_next;

    logic                         ram_we;
    logic [rtac_pkg::ADDR_W-1:0]  ram_wr_addr;
    logic [rtac_pkg::ENTRY_W-1:0] ram_wr_data;
    logic                         ram_re;
    logic [rtac_pkg::ADDR_W-1:0]  ram_rd_addr;
    logic [rtac_pkg::ENTRY_W-1:0] ram_rd_data;

    rtac_pkg::entry_t             rd_entry;
    rtac_pkg::entry_t             new_entry;
    logic [rtac_pkg::CNT_W-1:0]   sel_hint;
    logic [rtac_pkg::CNT_W-1:0]   last_idx;
    logic                         span_inside;
    logic                         exact_match;
    logic                         rights_ok;
    logic                         hit;
    logic                         more;
    logic                         out_free;
    logic                         take;
    logic                         finish;
    rtac_pkg::status_t            fin_status;
    logic                         set_hint;
    logic [rtac_pkg::CNT_W-1:0]   hint_value;

    rtac_ram #(
        .WIDTH (rtac_pkg::ENTRY_W),
        .DEPTH (rtac_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_entry           = rtac_pkg::entry_t'(ram_rd_data);
    assign new_entry.base     = cmd_reg.address;
    assign new_entry.end_addr = cmd_reg.end_addr;
    assign new_entry.rights   = cmd_reg.rights;

    assign sel_hint    = cmd_reg.use_write ? write_hint_reg : read_hint_reg;
    assign last_idx    = count_reg - rtac_pkg::CNT_W'(1);
    assign span_inside = (cmd_reg.address >= rd_entry.base) &&
                         (cmd_reg.end_addr <= rd_entry.end_addr);
    // Equal base and equal end imply equal length, since stored regions never wrap.
    assign exact_match = (cmd_reg.address == rd_entry.base) &&
                         (cmd_reg.end_addr == rd_entry.end_addr);
    assign rights_ok   = ((rd_entry.rights & cmd_reg.rights) == cmd_reg.rights);
    assign hit         = eval_valid_reg &&
                         ((cmd_reg.op == rtac_pkg::OP_REMOVE) ? exact_match : span_inside);
    assign more        = (rd_idx_reg < count_reg);
    assign out_free    = !out_valid_reg || rsp.ready;
    assign take        = (state_reg == rtac_pkg::S_IDLE) && q_valid && out_free;
    assign q_pop       = take;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtac_pkg::S_IDLE:
            begin
                if (take)
                begin
                    state_next = rtac_pkg::S_START;
                end
            end
            rtac_pkg::S_START:
            begin
                case (cmd_reg.op)
                    rtac_pkg::OP_CHECK:
                    begin
                        if (cmd_reg.zero_len || cmd_reg.wrap)
                        begin
                            state_next = rtac_pkg::S_IDLE;
                        end
                        else if (sel_hint < count_reg)
                        begin
                            state_next = rtac_pkg::S_HINT_EV;
                        end
                        else
                        begin
                            state_next = rtac_pkg::S_SCAN;
                        end
                    end
                    rtac_pkg::OP_REMOVE:
                    begin
                        state_next = rtac_pkg::S_SCAN;
                    end
                    default:
                    begin
                        state_next = rtac_pkg::S_IDLE;
                    end
                endcase
            end
            rtac_pkg::S_HINT_EV:
            begin
                state_next = span_inside ? rtac_pkg::S_IDLE : rtac_pkg::S_SCAN;
            end
            rtac_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    state_next = (cmd_reg.op == rtac_pkg::OP_REMOVE) ?
                                 rtac_pkg::S_MOVE_WR : rtac_pkg::S_IDLE;
                end
                else if (!more)
                begin
                    state_next = rtac_pkg::S_IDLE;
                end
            end
            rtac_pkg::S_MOVE_WR:
            begin
                state_next = rtac_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rtac_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        read_hint_next  = read_hint_reg;
        write_hint_next = write_hint_reg;
        rd_idx_next     = rd_idx_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = rtac_pkg::ENTRY_W'(new_entry);
        ram_re          = 1'b0;
        ram_rd_addr     = '0;
        finish          = 1'b0;
        fin_status      = rtac_pkg::STS_OK;
        set_hint        = 1'b0;
        hint_value      = rtac_pkg::HINT_NONE;

        case (state_reg)
            rtac_pkg::S_IDLE:
            begin
                if (take)
                begin
                    cmd_next = q_cmd;
                end
            end
            rtac_pkg::S_START:
            begin
                rd_idx_next     = '0;
                eval_valid_next = 1'b0;
                case (cmd_reg.op)
                    rtac_pkg::OP_ADD:
                    begin
                        finish = 1'b1;
                        if (cmd_reg.zero_len || cmd_reg.wrap)
                        begin
                            fin_status = rtac_pkg::STS_INVALID;
                        end
                        else if (count_reg >= rtac_pkg::FULL_COUNT)
                        begin
                            fin_status = rtac_pkg::STS_FULL;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            ram_wr_addr = count_reg[rtac_pkg::ADDR_W-1:0];
                            count_next  = count_reg + rtac_pkg::CNT_W'(1);
                        end
                    end
                    rtac_pkg::OP_CHECK:
                    begin
                        if (cmd_reg.zero_len)
                        begin
                            finish = 1'b1;
                        end
                        else if (cmd_reg.wrap)
                        begin
                            finish     = 1'b1;
                            fin_status = rtac_pkg::STS_DENIED;
                        end
                        else if (sel_hint < count_reg)
                        begin
                            ram_re      = 1'b1;
                            ram_rd_addr = sel_hint[rtac_pkg::ADDR_W-1:0];
                        end
                    end
                    rtac_pkg::OP_CLEAR:
                    begin
                        count_next      = '0;
                        read_hint_next  = rtac_pkg::HINT_NONE;
                        write_hint_next = rtac_pkg::HINT_NONE;
                        finish          = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            rtac_pkg::S_HINT_EV:
            begin
                if (span_inside)
                begin
                    finish     = 1'b1;
                    fin_status = rights_ok ? rtac_pkg::STS_OK : rtac_pkg::STS_DENIED;
                end
            end
            rtac_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    if (cmd_reg.op == rtac_pkg::OP_REMOVE)
                    begin
                        // Fetch the last entry; it moves into the freed place.
                        ram_re      = 1'b1;
                        ram_rd_addr = last_idx[rtac_pkg::ADDR_W-1:0];
                    end
                    else
                    begin
                        finish = 1'b1;
                        if (rights_ok)
                        begin
                            set_hint   = 1'b1;
                            hint_value = rtac_pkg::CNT_W'(eval_idx_reg);
                        end
                        else
                        begin
                            fin_status = rtac_pkg::STS_DENIED;
                        end
                    end
                end
                else if (more)
                begin
                    ram_re          = 1'b1;
                    ram_rd_addr     = rd_idx_reg[rtac_pkg::ADDR_W-1:0];
                    eval_valid_next = 1'b1;
                    eval_idx_next   = rd_idx_reg[rtac_pkg::ADDR_W-1:0];
                    rd_idx_next     = rd_idx_reg + rtac_pkg::CNT_W'(1);
                end
                else
                begin
                    finish = 1'b1;
                    if (cmd_reg.op == rtac_pkg::OP_REMOVE)
                    begin
                        fin_status = rtac_pkg::STS_NOT_FOUND;
                    end
                    else
                    begin
                        fin_status = rtac_pkg::STS_DENIED;
                        set_hint   = 1'b1;
                        hint_value = rtac_pkg::HINT_NONE;
                    end
                end
            end
            rtac_pkg::S_MOVE_WR:
            begin
                ram_we          = 1'b1;
                ram_wr_addr     = eval_idx_reg;
                ram_wr_data     = ram_rd_data;
                count_next      = last_idx;
                read_hint_next  = rtac_pkg::HINT_NONE;
                write_hint_next = rtac_pkg::HINT_NONE;
                finish          = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (set_hint)
        begin
            if (cmd_reg.use_write)
            begin
                write_hint_next = hint_value;
            end
            else
            begin
                read_hint_next = hint_value;
            end
        end

        // The result register is always empty here: an item is only taken when it is free.
        if (finish)
        begin
            out_valid_next  = 1'b1;
            out_status_next = fin_status;
            out_count_next  = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rtac_pkg::S_IDLE;
            count_reg      <= '0;
            read_hint_reg  <= rtac_pkg::HINT_NONE;
            write_hint_reg <= rtac_pkg::HINT_NONE;
            rd_idx_reg     <= '0;
            eval_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            read_hint_reg  <= read_hint_next;
            write_hint_reg <= write_hint_next;
            rd_idx_reg     <= rd_idx_next;
            eval_valid_reg <= eval_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        eval_idx_reg   <= eval_idx_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.region_count = rtac_pkg::COUNT_W'(out_count_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rtac_pkg::FULL_COUNT)
        else $error("region count exceeds table depth");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> !out_valid_reg || rsp.ready)
        else $error("result produced while the result register is still occupied");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rtac_pkg::S_SCAN && eval_valid_reg) |->
        (rtac_pkg::CNT_W'(eval_idx_reg) < count_reg))
        else $error("scan evaluates an entry beyond the table fill");

    a_remove_clears_hints: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rtac_pkg::S_MOVE_WR |=>
        (read_hint_reg == rtac_pkg::HINT_NONE && write_hint_reg == rtac_pkg::HINT_NONE))
        else $error("hints not cleared after a remove");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rtac_pkg::S_MOVE_WR |=>
        count_reg == $past(count_reg) - rtac_pkg::CNT_W'(1))
        else $error("remove did not shrink the table by one");
`endif

endmodule

// ----- rtl/region_table_access_checker_top.sv -----
// Channel | Role   | Fields
// req     | sink   | operation, address, length, permissions
// rsp     | source | status, region_count
//
// The back end handles one transaction at a time; the front end and a two-entry queue
// keep accepting transactions while the queue has room. Add and clear finish in the start
// state; check ends on a hint hit without a scan; remove scans, then moves the last entry into
// the freed place. The scan reads one table entry per cycle through the RAM read port.
// rst_n is asynchronous and active low; it empties the table and the queue at once.
// A stalled rsp holds its result; the back end picks up no new transaction until it is taken.
module region_table_access_checker_top (
    input  logic        clk,
    input  logic        rst_n,
    rtac_req_if.sink    req,
    rtac_rsp_if.source  rsp
);

    logic            push_valid;
    logic            push_ready;
    rtac_pkg::cmd_t  push_cmd;
    logic            pop_valid;
    logic            pop_ready;
    rtac_pkg::cmd_t  pop_cmd;

    rtac_front u_front (
        .req        (req),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    rtac_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    rtac_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_cmd   (pop_cmd),
        .q_pop   (pop_ready),
        .rsp     (rsp)
    );

endmodule
